/* design/fpm_pkg.sv */
// Package for the binary32 multiplier: field widths and exponent codes.
// No dependencies.
package fpm_pkg;
  localparam int unsigned WordWidth = 32;
  localparam logic [7:0] ExpAllOnes = 8'hFF;
  localparam logic [7:0] ExpZero    = 8'h00;
  localparam int signed  ExpBias    = 127;
  localparam logic [31:0] DefaultNan = 32'hFFC00000;
  localparam logic [31:0] QuietBit   = 32'h00400000;
  localparam logic [30:0] InfMag     = 31'h7F800000;

  typedef logic [WordWidth-1:0] word_t;

  // Operand classification passed from the input stage to the core.
  typedef struct packed {
    logic a_nan;
    logic b_nan;
    logic a_inf;
    logic b_inf;
    logic a_zero;
    logic b_zero;
  } class_t;
endpackage

/* design/fpm_stream_if.sv */
// Valid/ready channel carrying one 32-bit word.
// Depends on fpm_pkg.
interface fpm_stream_if;
  import fpm_pkg::*;
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/fpm_op_if.sv */
// Valid/ready channel carrying an operand pair.
// Depends on fpm_pkg.
interface fpm_op_if;
  import fpm_pkg::*;
  logic  valid;
  logic  ready;
  word_t op_a;
  word_t op_b;
  modport source (output valid, output op_a, output op_b, input ready);
  modport sink   (input valid, input op_a, input op_b, output ready);
endinterface

/* design/fpm_classify.sv */
// Operand classification for the binary32 multiplier.
// Depends on fpm_pkg.
module fpm_classify (
  input  fpm_pkg::word_t  a,
  input  fpm_pkg::word_t  b,
  output fpm_pkg::class_t cls
);
  import fpm_pkg::*;
  // Decode exponent and mantissa of each operand
  always_comb begin
    cls.a_nan  = (a[30:23] == ExpAllOnes) && (a[22:0] != '0);
    cls.b_nan  = (b[30:23] == ExpAllOnes) && (b[22:0] != '0);
    cls.a_inf  = (a[30:23] == ExpAllOnes) && (a[22:0] == '0);
    cls.b_inf  = (b[30:23] == ExpAllOnes) && (b[22:0] == '0);
    cls.a_zero = (a[30:23] == ExpZero) && (a[22:0] == '0);
    cls.b_zero = (b[30:23] == ExpZero) && (b[22:0] == '0);
  end
endmodule

/* design/fpm_core.sv */
// Significand multiply, normalize, round and special-case select.
// Depends on fpm_pkg.
module fpm_core (
  input  fpm_pkg::word_t  a,
  input  fpm_pkg::word_t  b,
  input  fpm_pkg::class_t cls,
  output fpm_pkg::word_t  product
);
  import fpm_pkg::*;
  logic [23:0] ma, mb;
  logic [47:0] p, pn;
  logic [5:0]  lz;
  logic signed [10:0] e;
  logic [6:0]  rsh;
  logic [48:0] shifted;
  logic [24:0] q;
  logic [32:0] packed_w;
  logic        sign;

  always_comb begin
    sign = a[31] ^ b[31];
    ma = {a[30:23] != ExpZero, a[22:0]};
    mb = {b[30:23] != ExpZero, b[22:0]};
    p = ma * mb;
    // Count leading zeros of the product
    lz = 6'd47;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) lz = 6'(47 - i);
    end
    // Normalize so that the leading one sits at bit 47
    pn = p << lz;
    e = 11'(signed'({3'b0, (a[30:23] == ExpZero) ? 8'd1 : a[30:23]}))
      + 11'(signed'({3'b0, (b[30:23] == ExpZero) ? 8'd1 : b[30:23]}))
      - 11'(ExpBias) + 11'sd1 - 11'(signed'({5'b0, lz}));
    // Extra right shift for denormal results
    if (e < 11'sd1) begin
      rsh = (e < -11'sd48) ? 7'd49 : 7'(11'sd1 - e);
    end else begin
      rsh = '0;
    end
    // Keep 24 bits plus guard, then round
    shifted = {pn, 1'b0} >> rsh;
    q = {1'b0, shifted[48:25]} + {24'b0, shifted[24]};
    if (e >= 11'sd1) begin
      packed_w = {10'(e - 11'sd1), 23'b0} + {8'b0, q};
    end else begin
      packed_w = {8'b0, q};
    end
    // Select special cases in priority order
    if (cls.a_nan) product = a | QuietBit;
    else if (cls.b_nan) product = b | QuietBit;
    else if ((cls.a_inf && cls.b_zero) || (cls.a_zero && cls.b_inf)) product = DefaultNan;
    else if (cls.a_inf || cls.b_inf) product = {sign, InfMag};
    else if (cls.a_zero || cls.b_zero) product = {sign, 31'b0};
    else if (packed_w >= {2'b0, ExpAllOnes, 23'b0}) product = {sign, InfMag};
    else product = {sign, packed_w[30:0]};
  end
endmodule

/* design/fp32_multiplier_unit.sv */
// Top level of the binary32 multiplier: input register, core, result register.
// Depends on fpm_pkg, fpm_op_if, fpm_stream_if, fpm_classify, fpm_core.
//
// Usage:
//   operands: sink channel with op_a and op_b, binary32 bit patterns.
//   result:   source channel whose data is the binary32 product.
//   An operand transfer loads the input register; result valid rises once
//   the multiply/normalize/round logic has loaded the result register. One
//   multiply is taken per cycle unless a stalled result holds it up; the
//   single 24x24 multiplier with its normalize and round path sits between
//   those two registers.
//   Ready to the sender drops only when both registers hold items and the
//   receiver stalls; the pipeline advances whenever the result register
//   empties or is being taken. A stalled result holds steady.
//   Reset (rst, synchronous) empties both stages; results in flight are
//   dropped and none is invented across it.
module fp32_multiplier_unit (
  input logic clk,
  input logic rst,
  fpm_op_if.sink       operands,
  fpm_stream_if.source result
);
  import fpm_pkg::*;
  logic  in_valid, out_valid;
  word_t in_a, in_b, out_data, core_product;
  class_t cls;
  logic  adv_out, adv_in;

  fpm_classify u_classify (.a(in_a), .b(in_b), .cls(cls));
  fpm_core u_core (.a(in_a), .b(in_b), .cls(cls), .product(core_product));

  assign adv_out = !out_valid || result.ready;
  assign adv_in  = !in_valid || adv_out;
  assign operands.ready = adv_in;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Advance the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_in) in_valid <= operands.valid;
      if (adv_out) out_valid <= in_valid;
    end
    if (adv_in && operands.valid) begin
      in_a <= operands.op_a;
      in_b <= operands.op_b;
    end
    if (adv_out && in_valid) out_data <= core_product;
  end
endmodule

/* design/fpm_checker.sv */
// Port-level checks for the binary32 multiplier, bound to the top level.
// Depends on fp32_multiplier_unit port names.
module fpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_data
);
  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // Input ready only drops while a result is stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("ready low without stall");
  // A transfer in with an idle output shows a result once it has passed the input and result registers
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing");
  // Nothing appears out of an empty block
  a_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind fp32_multiplier_unit fpm_checker u_fpm_checker (
  .clk(clk), .rst(rst),
  .in_valid(operands.valid), .in_ready(operands.ready),
  .out_valid(result.valid), .out_ready(result.ready),
  .out_data(result.data)
);
